/* rtl/burst_byte_ring_fifo_defines.svh */
// ----------------------------------------------------------------------------
// Burst byte ring FIFO assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BURST_BYTE_RING_FIFO_DEFINES_SVH
`define BURST_BYTE_RING_FIFO_DEFINES_SVH

`ifndef SYNTHESIS

`define BBRF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bbrf: implication check failed");

`define BBRF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bbrf: next-cycle check failed");

`else

`define BBRF_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define BBRF_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/bbrf_pkg.sv */
// ----------------------------------------------------------------------------
// Burst byte ring FIFO package
// Shared widths, codes and control structs for the lane datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bbrf_pkg;

   localparam int LANES     = 8;
   localparam int LANE_W    = 3;
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 4;
   localparam int FILL_W    = 9;
   localparam int MAX_BURST = 8;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef byte_type [LANES-1:0] lane_bytes_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [LANE_W-1:0] offset;
      logic [LEN_W-1:0]  len;
   } lane_ctrl_type;

   typedef struct packed {
      logic              pop;
      logic [LANE_W-1:0] offset;
      logic [LEN_W-1:0]  len;
   } merge_ctrl_type;

endpackage

`default_nettype wire

/* rtl/bbrf_if.sv */
// ----------------------------------------------------------------------------
// Burst byte ring FIFO channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbrf_req_if import bbrf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [LEN_W-1:0] burst_len;
   byte_type         in_byte0;
   byte_type         in_byte1;
   byte_type         in_byte2;
   byte_type         in_byte3;
   byte_type         in_byte4;
   byte_type         in_byte5;
   byte_type         in_byte6;
   byte_type         in_byte7;

   modport source (
      output valid, kind, burst_len,
      output in_byte0, in_byte1, in_byte2, in_byte3,
      output in_byte4, in_byte5, in_byte6, in_byte7,
      input  ready
   );

   modport sink (
      input  valid, kind, burst_len,
      input  in_byte0, in_byte1, in_byte2, in_byte3,
      input  in_byte4, in_byte5, in_byte6, in_byte7,
      output ready
   );
endinterface

interface bbrf_rsp_if import bbrf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              accepted;
   logic [FILL_W-1:0] fill_level;
   byte_type          out_byte0;
   byte_type          out_byte1;
   byte_type          out_byte2;
   byte_type          out_byte3;
   byte_type          out_byte4;
   byte_type          out_byte5;
   byte_type          out_byte6;
   byte_type          out_byte7;

   modport source (
      output valid, accepted, fill_level,
      output out_byte0, out_byte1, out_byte2, out_byte3,
      output out_byte4, out_byte5, out_byte6, out_byte7,
      input  ready
   );

   modport sink (
      input  valid, accepted, fill_level,
      input  out_byte0, out_byte1, out_byte2, out_byte3,
      input  out_byte4, out_byte5, out_byte6, out_byte7,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/burst_byte_ring_fifo.sv */
// An accepted transaction goes through the s1 stage and then the response register to the output.
// Throughput: one transaction per cycle without response stalls; lane RAMs take one burst per cycle.
// Stalls on the response channel back up through a single decision stage.
// Reset: synchronous, clears fill level, pointers and valid flags.
// The byte store needs no clearing: bytes are only read after being written.
// ----------------------------------------------------------------------------
// Burst byte ring FIFO
// Eight byte lanes store bursts of up to eight bytes, all or nothing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "burst_byte_ring_fifo_defines.svh"

module burst_byte_ring_fifo import bbrf_pkg::*; #(
   parameter int DEPTH = 256
) (
   input wire logic    clock,
   input wire logic    reset,
   bbrf_req_if.sink    req_ch,
   bbrf_rsp_if.source  rsp_ch
);

   localparam int ROWS  = (DEPTH + LANES - 1) / LANES;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);
   localparam int SUM_W = LVL_W + 1;

   logic [LVL_W-1:0]  level_ff, level_in;
   logic [ROW_W-1:0]  wr_row_ff, wr_row_in, rd_row_ff, rd_row_in;
   logic [LANE_W-1:0] wr_off_ff, wr_off_in, rd_off_ff, rd_off_in;

   logic              s1_valid_ff;
   logic              s1_accepted_ff;
   logic [FILL_W-1:0] s1_fill_ff;
   merge_ctrl_type    s1_mctrl_ff;

   logic              rsp_valid_ff;
   logic              rsp_accepted_ff;
   logic [FILL_W-1:0] rsp_fill_ff;
   lane_bytes_type    rsp_bytes_ff;

   logic              accept, s1_adv, is_pop, len_ok, op_ok;
   logic [LEN_W-1:0]  len;
   logic [SUM_W-1:0]  level_ext, len_ext;
   logic [LVL_W-1:0]  level_next;
   logic [LEN_W-1:0]  wr_sum, rd_sum;
   logic [ROW_W-1:0]  wr_row_inc, rd_row_inc, lane_row, lane_row_next;
   lane_ctrl_type     lane_ctrl;
   lane_bytes_type    wr_bytes, lane_q, merged;

   function automatic logic [ROW_W-1:0] row_step(input logic [ROW_W-1:0] r);
      return (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
   endfunction

   assign s1_adv       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign accept       = req_ch.valid && req_ch.ready;

   assign is_pop    = (req_ch.kind == KIND_POP);
   assign len       = req_ch.burst_len;
   assign len_ok    = (len <= LEN_W'(MAX_BURST));
   assign level_ext = SUM_W'(level_ff);
   assign len_ext   = SUM_W'(len);

   always_comb begin
      if (is_pop) begin
         op_ok      = len_ok && (len_ext <= level_ext);
         level_next = LVL_W'(level_ext - len_ext);
      end else begin
         op_ok      = len_ok && ((level_ext + len_ext) <= SUM_W'(DEPTH));
         level_next = LVL_W'(level_ext + len_ext);
      end
   end

   assign wr_sum     = LEN_W'(wr_off_ff) + len;
   assign rd_sum     = LEN_W'(rd_off_ff) + len;
   assign wr_row_inc = row_step(wr_row_ff);
   assign rd_row_inc = row_step(rd_row_ff);

   always_comb begin
      level_in  = level_ff;
      wr_row_in = wr_row_ff;
      wr_off_in = wr_off_ff;
      rd_row_in = rd_row_ff;
      rd_off_in = rd_off_ff;
      if (accept && op_ok) begin
         level_in = level_next;
         if (is_pop) begin
            rd_off_in = rd_sum[LANE_W-1:0];
            rd_row_in = rd_sum[LANE_W] ? rd_row_inc : rd_row_ff;
         end else begin
            wr_off_in = wr_sum[LANE_W-1:0];
            wr_row_in = wr_sum[LANE_W] ? wr_row_inc : wr_row_ff;
         end
      end
   end

   assign lane_row      = is_pop ? rd_row_ff : wr_row_ff;
   assign lane_row_next = is_pop ? rd_row_inc : wr_row_inc;

   assign lane_ctrl.wr_en  = accept && op_ok && !is_pop;
   assign lane_ctrl.rd_en  = accept && op_ok && is_pop;
   assign lane_ctrl.offset = is_pop ? rd_off_ff : wr_off_ff;
   assign lane_ctrl.len    = len;

   assign wr_bytes[0] = req_ch.in_byte0;
   assign wr_bytes[1] = req_ch.in_byte1;
   assign wr_bytes[2] = req_ch.in_byte2;
   assign wr_bytes[3] = req_ch.in_byte3;
   assign wr_bytes[4] = req_ch.in_byte4;
   assign wr_bytes[5] = req_ch.in_byte5;
   assign wr_bytes[6] = req_ch.in_byte6;
   assign wr_bytes[7] = req_ch.in_byte7;

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      bbrf_lane #(
         .LANE  (j),
         .ROWS  (ROWS),
         .ROW_W (ROW_W)
      ) u_lane (
         .clock    (clock),
         .ctrl     (lane_ctrl),
         .row      (lane_row),
         .row_next (lane_row_next),
         .wr_bytes (wr_bytes),
         .rd_byte  (lane_q[j])
      );
   end

   bbrf_merge u_merge (
      .ctrl      (s1_mctrl_ff),
      .lane_q    (lane_q),
      .out_bytes (merged)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         wr_row_ff    <= '0;
         wr_off_ff    <= '0;
         rd_row_ff    <= '0;
         rd_off_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff  <= level_in;
         wr_row_ff <= wr_row_in;
         wr_off_ff <= wr_off_in;
         rd_row_ff <= rd_row_in;
         rd_off_ff <= rd_off_in;
         if (req_ch.ready) begin
            s1_valid_ff <= accept;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_accepted_ff     <= op_ok;
         s1_fill_ff         <= FILL_W'(level_in);
         s1_mctrl_ff.pop    <= op_ok && is_pop;
         s1_mctrl_ff.offset <= rd_off_ff;
         s1_mctrl_ff.len    <= len;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_accepted_ff <= s1_accepted_ff;
         rsp_fill_ff     <= s1_fill_ff;
         rsp_bytes_ff    <= merged;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.accepted   = rsp_accepted_ff;
   assign rsp_ch.fill_level = rsp_fill_ff;
   assign rsp_ch.out_byte0  = rsp_bytes_ff[0];
   assign rsp_ch.out_byte1  = rsp_bytes_ff[1];
   assign rsp_ch.out_byte2  = rsp_bytes_ff[2];
   assign rsp_ch.out_byte3  = rsp_bytes_ff[3];
   assign rsp_ch.out_byte4  = rsp_bytes_ff[4];
   assign rsp_ch.out_byte5  = rsp_bytes_ff[5];
   assign rsp_ch.out_byte6  = rsp_bytes_ff[6];
   assign rsp_ch.out_byte7  = rsp_bytes_ff[7];

   `BBRF_ASSERT_IMP(a_level_bound, clock, reset, 1'b1, level_ff <= LVL_W'(DEPTH))
   `BBRF_ASSERT_NXT(a_accept_fills_s1, clock, reset, accept, s1_valid_ff)
   `BBRF_ASSERT_NXT(a_s1_holds, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff && $stable(s1_mctrl_ff))
   `BBRF_ASSERT_NXT(a_level_idle, clock, reset, !accept, $stable(level_ff))
   `BBRF_ASSERT_IMP(a_reject_zero, clock, reset, rsp_valid_ff && !rsp_accepted_ff, rsp_bytes_ff == '0)

endmodule

`default_nettype wire

/* rtl/bbrf_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write port, registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module bbrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/bbrf_lane.sv */
// ----------------------------------------------------------------------------
// Burst byte ring FIFO lane
// One byte bank: picks its byte of the burst and its row, writes or reads.
// ----------------------------------------------------------------------------
`default_nettype none

module bbrf_lane import bbrf_pkg::*; #(
   parameter int LANE  = 0,
   parameter int ROWS  = 32,
   parameter int ROW_W = 5
) (
   input  wire logic           clock,
   input  wire lane_ctrl_type  ctrl,
   input  wire logic [ROW_W-1:0] row,
   input  wire logic [ROW_W-1:0] row_next,
   input  wire lane_bytes_type wr_bytes,
   output      byte_type       rd_byte
);

   localparam logic [LANE_W-1:0] LANE_ID = LANE_W'(LANE);

   logic [LANE_W-1:0] burst_idx;
   logic [ROW_W-1:0]  addr;
   logic              wr_en;

   assign burst_idx = LANE_ID - ctrl.offset;
   assign addr      = (LANE_ID >= ctrl.offset) ? row : row_next;
   assign wr_en     = ctrl.wr_en && (LEN_W'(burst_idx) < ctrl.len);

   bbrf_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (ROWS),
      .ADDR_W (ROW_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (ctrl.rd_en),
      .addr    (addr),
      .wr_data (wr_bytes[burst_idx]),
      .rd_data (rd_byte)
   );

endmodule

`default_nettype wire

/* rtl/bbrf_merge.sv */
// ----------------------------------------------------------------------------
// Burst byte ring FIFO merge
// Rotate the lane read data into burst order and zero unused positions.
// ----------------------------------------------------------------------------
`default_nettype none

module bbrf_merge import bbrf_pkg::*; (
   input  wire merge_ctrl_type ctrl,
   input  wire lane_bytes_type lane_q,
   output      lane_bytes_type out_bytes
);

   always_comb begin
      logic [LANE_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < LANES; i++) begin
         idx = ctrl.offset + LANE_W'(i);
         if (ctrl.pop && (LEN_W'(i) < ctrl.len)) begin
            out_bytes[i] = lane_q[idx];
         end else begin
            out_bytes[i] = '0;
         end
      end
   end

endmodule

`default_nettype wire

/* bench/burst_byte_ring_fifo_tb.sv */
// ----------------------------------------------------------------------------
// Burst byte ring FIFO testbench
// Drives push and pop bursts through the request channel with random idling
// on both sides, predicts every response from a byte-accurate ring model in
// a small scoreboard, and checks each response field by field.
// ----------------------------------------------------------------------------
module burst_byte_ring_fifo_tb import bbrf_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CAPACITY    = 256;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          LATENCY     = 2;
   localparam int unsigned ITEM_COUNT  = 1950;

   typedef struct packed {
      logic             kind;
      logic [LEN_W-1:0] len;
      lane_bytes_type   data;
   } burst_req_type;

   typedef struct packed {
      logic              accepted;
      logic [FILL_W-1:0] fill_level;
      lane_bytes_type    data;
   } fifo_result_type;

   class ring_fifo_scoreboard;
      byte_type        store [CAPACITY];
      int unsigned     wr_count;
      int unsigned     rd_count;
      fifo_result_type due_responses [$];
      int unsigned     mismatches;

      function new();
         foreach (store[i]) store[i] = '0;
         wr_count   = 0;
         rd_count   = 0;
         mismatches = 0;
      endfunction

      function int unsigned fill();
         return (wr_count + 2 * CAPACITY - rd_count) % (2 * CAPACITY);
      endfunction

      function void note_request(burst_req_type r);
         fifo_result_type exp;
         int unsigned     level;
         exp   = '0;
         level = fill();
         if (r.len <= MAX_BURST) begin
            if (r.kind == KIND_PUSH) begin
               if (r.len + level <= CAPACITY) begin
                  for (int i = 0; i < r.len; i++)
                     store[(wr_count + i) % CAPACITY] = r.data[i];
                  wr_count     = (wr_count + r.len) % (2 * CAPACITY);
                  exp.accepted = 1'b1;
               end
            end else begin
               if (r.len <= level) begin
                  for (int i = 0; i < r.len; i++) begin
                     exp.data[i] = store[(rd_count + i) % CAPACITY];
                     store[(rd_count + i) % CAPACITY] = '0;
                  end
                  rd_count     = (rd_count + r.len) % (2 * CAPACITY);
                  exp.accepted = 1'b1;
               end
            end
         end
         exp.fill_level = FILL_W'(fill());
         due_responses.push_back(exp);
      endfunction

      function void check_response(fifo_result_type got);
         fifo_result_type exp;
         if (due_responses.size() == 0) begin
            $error("response with none outstanding: accepted %0d fill_level %0d",
                   got.accepted, got.fill_level);
            mismatches++;
            return;
         end
         exp = due_responses.pop_front();
         if (got.accepted !== exp.accepted) begin
            $error("accepted: expected %0d, got %0d", exp.accepted, got.accepted);
            mismatches++;
         end
         if (got.fill_level !== exp.fill_level) begin
            $error("fill_level: expected %0d, got %0d", exp.fill_level, got.fill_level);
            mismatches++;
         end
         for (int i = 0; i < LANES; i++) begin
            if (got.data[i] !== exp.data[i]) begin
               $error("out_byte%0d: expected 8'h%02h, got 8'h%02h",
                      i, exp.data[i], got.data[i]);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bbrf_req_if req_ch ();
   bbrf_rsp_if rsp_ch ();

   burst_byte_ring_fifo #(
      .DEPTH (CAPACITY)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ring_fifo_scoreboard sb = new();

   int unsigned send_idle_pct = 24;
   int unsigned recv_idle_pct = 80;
   int unsigned cycle_count   = 0;
   bit          filling       = 1'b1;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      burst_req_type r;
      if (!reset && req_ch.valid && req_ch.ready) begin
         r.kind    = req_ch.kind;
         r.len     = req_ch.burst_len;
         r.data[0] = req_ch.in_byte0;
         r.data[1] = req_ch.in_byte1;
         r.data[2] = req_ch.in_byte2;
         r.data[3] = req_ch.in_byte3;
         r.data[4] = req_ch.in_byte4;
         r.data[5] = req_ch.in_byte5;
         r.data[6] = req_ch.in_byte6;
         r.data[7] = req_ch.in_byte7;
         sb.note_request(r);
      end
   end

   always @(posedge clock) begin
      fifo_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.accepted   = rsp_ch.accepted;
         got.fill_level = rsp_ch.fill_level;
         got.data[0]    = rsp_ch.out_byte0;
         got.data[1]    = rsp_ch.out_byte1;
         got.data[2]    = rsp_ch.out_byte2;
         got.data[3]    = rsp_ch.out_byte3;
         got.data[4]    = rsp_ch.out_byte4;
         got.data[5]    = rsp_ch.out_byte5;
         got.data[6]    = rsp_ch.out_byte6;
         got.data[7]    = rsp_ch.out_byte7;
         sb.check_response(got);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("burst_byte_ring_fifo_tb: done, errors");
      $finish;
   end

   task automatic send_burst(logic kind, logic [LEN_W-1:0] len, lane_bytes_type data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= kind;
      req_ch.burst_len <= len;
      req_ch.in_byte0  <= data[0];
      req_ch.in_byte1  <= data[1];
      req_ch.in_byte2  <= data[2];
      req_ch.in_byte3  <= data[3];
      req_ch.in_byte4  <= data[4];
      req_ch.in_byte5  <= data[5];
      req_ch.in_byte6  <= data[6];
      req_ch.in_byte7  <= data[7];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // sweep between empty and full: lean towards pushes until nearly full,
   // then towards pops until nearly empty
   task automatic send_random(int unsigned count);
      logic             kind;
      logic [LEN_W-1:0] len;
      lane_bytes_type   data;
      int unsigned      push_pct;
      for (int unsigned n = 0; n < count; n++) begin
         if (sb.fill() >= CAPACITY - 2)
            filling = 1'b0;
         else if (sb.fill() <= 2)
            filling = 1'b1;
         push_pct = filling ? 75 : 25;
         kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
         if ($urandom_range(99) < 8)
            len = LEN_W'($urandom_range(15, MAX_BURST + 1));
         else
            len = LEN_W'($urandom_range(MAX_BURST));
         data = {$urandom, $urandom};
         send_burst(kind, len, data);
      end
   endtask

   initial begin
      int unsigned per_stage;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= KIND_PUSH;
      req_ch.burst_len <= '0;
      req_ch.in_byte0  <= '0;
      req_ch.in_byte1  <= '0;
      req_ch.in_byte2  <= '0;
      req_ch.in_byte3  <= '0;
      req_ch.in_byte4  <= '0;
      req_ch.in_byte5  <= '0;
      req_ch.in_byte6  <= '0;
      req_ch.in_byte7  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty store: zero-length and short pops, then zero-length and full pushes
      send_burst(KIND_POP,  4'd0, '0);
      send_burst(KIND_POP,  4'd1, '0);
      send_burst(KIND_PUSH, 4'd0, {8{8'h5A}});
      send_burst(KIND_PUSH, 4'd8, {8{8'hFF}});
      send_burst(KIND_PUSH, 4'd8, {8{8'h00}});
      // oversized bursts, then pops and pushes of mixed lengths
      send_burst(KIND_PUSH, 4'd15, {8{8'hFF}});
      send_burst(KIND_PUSH, 4'd9, {8{8'hAA}});
      send_burst(KIND_POP,  4'd9, '0);
      send_burst(KIND_POP,  4'd15, {8{8'hFF}});
      send_burst(KIND_POP,  4'd3, '0);
      send_burst(KIND_POP,  4'd8, '0);
      send_burst(KIND_POP,  4'd6, '0);
      send_burst(KIND_POP,  4'd5, '0);
      send_burst(KIND_PUSH, 4'd1, {8{8'hA5}});
      send_burst(KIND_PUSH, 4'd7, 64'h0180_4020_1008_0402);
      send_burst(KIND_POP,  4'd0, '0);
      send_burst(KIND_POP,  4'd8, '0);
      send_burst(KIND_POP,  4'd1, '0);

      per_stage = (ITEM_COUNT - 18) / 3;
      send_random(per_stage);
      send_idle_pct = 80;
      recv_idle_pct = 24;
      send_random(per_stage);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(per_stage);
      req_ch.valid <= 1'b0;

      while (sb.due_responses.size() != 0) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);

      if (sb.mismatches == 0)
         $display("burst_byte_ring_fifo_tb: done, clean");
      else
         $display("burst_byte_ring_fifo_tb: done, errors");
      $finish;
   end

endmodule

/* burst_byte_ring_fifo.f */
+incdir+rtl
rtl/bbrf_pkg.sv
rtl/bbrf_if.sv
rtl/bbrf_ram.sv
rtl/bbrf_lane.sv
rtl/bbrf_merge.sv
rtl/burst_byte_ring_fifo.sv
bench/burst_byte_ring_fifo_tb.sv
